>>> design/udrb_pkg.sv
`default_nettype none

package udrb_pkg;

  // default ring depth and byte width
  localparam int unsigned DefaultDepth = 256;
  localparam int unsigned ByteW        = 8;

  // request kind codes
  localparam logic [1:0] KIND_TX_QUEUE = 2'd0;
  localparam logic [1:0] KIND_RX_READ  = 2'd1;
  localparam logic [1:0] KIND_LINE_EVT = 2'd2;

  // one request from the host or the line
  typedef struct packed {
    logic [1:0]       kind;
    logic [ByteW-1:0] host_byte;
    logic [ByteW-1:0] line_byte;
    logic             byte_received;
    logic             line_error;
    logic             transmitter_empty;
  } req_t;

  // one result per request
  typedef struct packed {
    logic [ByteW-1:0] read_byte;
    logic             read_had_data;
    logic             queue_accepted;
    logic             send_valid;
    logic [ByteW-1:0] send_byte;
    logic             rx_dropped;
    logic             rx_available;
    logic             tx_armed;
  } res_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

>>> design/uart_dual_ring_buffer.sv
// channel   | direction | handshake                  | payload
// request   | in        | start_i high, busy_o low   | req_i
// result    | out       | done_o high for one cycle  | result_o
//
// for each request, the accept cycle reads the head of both
// rings from their memories, the following cycle updates the rings and
// registers the result, which shows with done_o in the next cycle while a
// new request may already be accepted. the registered memory read is why the rings update after the accept cycle.
// reset clears the four ring pointers and the transmit arm flag; ring
// contents are not cleared. the receiver cannot stall the result.
`default_nettype none

module uart_dual_ring_buffer import udrb_pkg::*; #(
  parameter int unsigned Depth = DefaultDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire req_t req_i,
  output logic      busy_o,
  output logic      done_o,
  output res_t      result_o
);

  cmd_t cmd;

  // sequencing
  udrb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // rings, pointers and result
  udrb_dp #(
    .Depth (Depth)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .req_i    (req_i),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

>>> design/udrb_ram.sv
`default_nettype none

module udrb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/udrb_ctrl.sv
`default_nettype none

module udrb_ctrl import udrb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic      busy_o,
  output logic      done_o,
  output cmd_t      cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;
  logic   accept;

  // a request is taken while not busy
  assign accept = start_i & ~busy_q;

  // state, busy and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          done_q <= 1'b0;
          if (accept) begin
            state_q <= ST_EXEC;
            busy_q  <= 1'b1;
          end
        end
        ST_EXEC: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  // commands to the datapath
  assign cmd_o.load = accept;
  assign cmd_o.exec = (state_q == ST_EXEC);

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> design/udrb_dp.sv
`default_nettype none

module udrb_dp import udrb_pkg::*; #(
  parameter int unsigned Depth = DefaultDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t cmd_i,
  input  wire req_t req_i,
  output res_t      result_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  req_t req_q;
  res_t res_q, res_d;

  logic [PtrW-1:0] tx_wptr_q, tx_wptr_d, tx_rptr_q, tx_rptr_d;
  logic [PtrW-1:0] rx_wptr_q, rx_wptr_d, rx_rptr_q, rx_rptr_d;
  logic [PtrW-1:0] tx_wnext, tx_rnext, rx_wnext, rx_rnext;
  logic            armed_q, armed_d;

  logic             tx_we, rx_we;
  logic [ByteW-1:0] tx_rdata, rx_rdata;

  // pointer increment with wrap
  assign tx_wnext = (tx_wptr_q == PtrLast) ? '0 : tx_wptr_q + 1'b1;
  assign tx_rnext = (tx_rptr_q == PtrLast) ? '0 : tx_rptr_q + 1'b1;
  assign rx_wnext = (rx_wptr_q == PtrLast) ? '0 : rx_wptr_q + 1'b1;
  assign rx_rnext = (rx_rptr_q == PtrLast) ? '0 : rx_rptr_q + 1'b1;

  // ring stores, both read at the head on request load
  udrb_ram #(
    .Width (ByteW),
    .Depth (Depth)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_wptr_q),
    .wdata_i (req_q.host_byte),
    .re_i    (cmd_i.load),
    .raddr_i (tx_rptr_q),
    .rdata_o (tx_rdata)
  );

  udrb_ram #(
    .Width (ByteW),
    .Depth (Depth)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_wptr_q),
    .wdata_i (req_q.line_byte),
    .re_i    (cmd_i.load),
    .raddr_i (rx_rptr_q),
    .rdata_o (rx_rdata)
  );

  // request decode and next state
  always_comb begin
    tx_wptr_d = tx_wptr_q;
    tx_rptr_d = tx_rptr_q;
    rx_wptr_d = rx_wptr_q;
    rx_rptr_d = rx_rptr_q;
    armed_d   = armed_q;
    tx_we     = 1'b0;
    rx_we     = 1'b0;
    res_d     = '0;

    case (req_q.kind)
      KIND_TX_QUEUE: begin
        if (tx_wnext != tx_rptr_q) begin
          tx_we                = 1'b1;
          tx_wptr_d            = tx_wnext;
          res_d.queue_accepted = 1'b1;
        end
        armed_d = 1'b1;
      end
      KIND_RX_READ: begin
        if (rx_wptr_q != rx_rptr_q) begin
          res_d.read_byte     = rx_rdata;
          res_d.read_had_data = 1'b1;
          rx_rptr_d           = rx_rnext;
        end
      end
      KIND_LINE_EVT: begin
        if (!req_q.line_error) begin
          if (req_q.byte_received) begin
            if (rx_wnext != rx_rptr_q) begin
              rx_we     = 1'b1;
              rx_wptr_d = rx_wnext;
            end else begin
              res_d.rx_dropped = 1'b1;
            end
          end
          if (armed_q && req_q.transmitter_empty) begin
            if (tx_wptr_q != tx_rptr_q) begin
              res_d.send_byte  = tx_rdata;
              res_d.send_valid = 1'b1;
              tx_rptr_d        = tx_rnext;
            end else begin
              armed_d = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase

    res_d.rx_available = (rx_wptr_d != rx_rptr_d);
    res_d.tx_armed     = armed_d;

    // only act in the execute cycle
    if (!cmd_i.exec) begin
      tx_wptr_d = tx_wptr_q;
      tx_rptr_d = tx_rptr_q;
      rx_wptr_d = rx_wptr_q;
      rx_rptr_d = rx_rptr_q;
      armed_d   = armed_q;
      tx_we     = 1'b0;
      rx_we     = 1'b0;
    end
  end

  // ring pointers and transmit arm flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_wptr_q <= '0;
      tx_rptr_q <= '0;
      rx_wptr_q <= '0;
      rx_rptr_q <= '0;
      armed_q   <= 1'b0;
    end else begin
      tx_wptr_q <= tx_wptr_d;
      tx_rptr_q <= tx_rptr_d;
      rx_wptr_q <= rx_wptr_d;
      rx_rptr_q <= rx_rptr_d;
      armed_q   <= armed_d;
    end
  end

  // request and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

`default_nettype wire
